// ===== sv/crt_pkg.sv =====
`default_nettype none

package crt_pkg;

  // Field and datapath widths.
  localparam int COORD_W = 16;
  localparam int COEF_W = 20;
  localparam int ACC_W = 24;
  localparam int T_W = 17;
  localparam int PROD_W = ACC_W + T_W + 1;
  localparam int CNT_W = 5;
  localparam int SPP_W = 6;

  // Sample count limits and register reset.
  localparam logic [SPP_W-1:0] SPP_RESET = SPP_W'(16);
  localparam logic [SPP_W-1:0] MIN_SAMPLES = SPP_W'(2);
  localparam logic [SPP_W-1:0] MAX_SAMPLES = SPP_W'(32);

  // Segment queue depth.
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W = $clog2(FIFO_DEPTH);

  // Rounding constant for the Q0.16 product.
  localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(32768);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  // Doubled cubic coefficients of one coordinate.
  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } coef_t;

  // One segment as it travels from the front to the back.
  typedef struct packed {
    coef_t x;
    coef_t y;
    logic  last;
  } seg_t;

  // Step of the t accumulator: 65536 = q * m + r.
  typedef struct packed {
    logic [T_W-1:0]   q;
    logic [CNT_W-1:0] r;
  } tstep_t;

  // Coefficients from four control points.
  function automatic coef_t coef_f(input logic signed [COORD_W-1:0] p0,
                                   input logic signed [COORD_W-1:0] p1,
                                   input logic signed [COORD_W-1:0] p2,
                                   input logic signed [COORD_W-1:0] p3);
    logic signed [COEF_W-1:0] e0;
    logic signed [COEF_W-1:0] e1;
    logic signed [COEF_W-1:0] e2;
    logic signed [COEF_W-1:0] e3;
    coef_t r;
    e0 = COEF_W'(p0);
    e1 = COEF_W'(p1);
    e2 = COEF_W'(p2);
    e3 = COEF_W'(p3);
    r.a = e1 <<< 1;
    r.b = e2 - e0;
    r.c = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    r.d = e1 + (e1 <<< 1) - e2 - (e2 <<< 1) + e3 - e0;
    return r;
  endfunction

  // Quotient and remainder of 65536 by the segment's interval count.
  function automatic tstep_t tstep_f(input logic [CNT_W-1:0] m);
    tstep_t s;
    unique case (m)
      5'd2:    s = '{q: 17'd32768, r: 5'd0};
      5'd3:    s = '{q: 17'd21845, r: 5'd1};
      5'd4:    s = '{q: 17'd16384, r: 5'd0};
      5'd5:    s = '{q: 17'd13107, r: 5'd1};
      5'd6:    s = '{q: 17'd10922, r: 5'd4};
      5'd7:    s = '{q: 17'd9362,  r: 5'd2};
      5'd8:    s = '{q: 17'd8192,  r: 5'd0};
      5'd9:    s = '{q: 17'd7281,  r: 5'd7};
      5'd10:   s = '{q: 17'd6553,  r: 5'd6};
      5'd11:   s = '{q: 17'd5957,  r: 5'd9};
      5'd12:   s = '{q: 17'd5461,  r: 5'd4};
      5'd13:   s = '{q: 17'd5041,  r: 5'd3};
      5'd14:   s = '{q: 17'd4681,  r: 5'd2};
      5'd15:   s = '{q: 17'd4369,  r: 5'd1};
      5'd16:   s = '{q: 17'd4096,  r: 5'd0};
      5'd17:   s = '{q: 17'd3855,  r: 5'd1};
      5'd18:   s = '{q: 17'd3640,  r: 5'd16};
      5'd19:   s = '{q: 17'd3449,  r: 5'd5};
      5'd20:   s = '{q: 17'd3276,  r: 5'd16};
      5'd21:   s = '{q: 17'd3120,  r: 5'd16};
      5'd22:   s = '{q: 17'd2978,  r: 5'd20};
      5'd23:   s = '{q: 17'd2849,  r: 5'd9};
      5'd24:   s = '{q: 17'd2730,  r: 5'd16};
      5'd25:   s = '{q: 17'd2621,  r: 5'd11};
      5'd26:   s = '{q: 17'd2520,  r: 5'd16};
      5'd27:   s = '{q: 17'd2427,  r: 5'd7};
      5'd28:   s = '{q: 17'd2340,  r: 5'd16};
      5'd29:   s = '{q: 17'd2259,  r: 5'd25};
      5'd30:   s = '{q: 17'd2184,  r: 5'd16};
      5'd31:   s = '{q: 17'd2114,  r: 5'd2};
      default: s = '{q: 17'd65536, r: 5'd0};
    endcase
    return s;
  endfunction

  // Signed accumulator times unsigned t.
  function automatic logic signed [PROD_W-1:0] mul_f(input logic signed [ACC_W-1:0] acc,
                                                     input logic [T_W-1:0] t);
    return PROD_W'(acc) * $signed({1'b0, t});
  endfunction

  // Round a Q0.16 product back to coordinate scale, half up.
  function automatic logic signed [ACC_W-1:0] rnd_f(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + HALF_P;
    return ACC_W'(s >>> 16);
  endfunction

  // Halve with rounding and clamp to the coordinate range.
  function automatic logic signed [COORD_W-1:0] fin_f(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] h;
    h = (acc + ACC_W'(1)) >>> 1;
    if (h > SAT_HI) begin
      h = SAT_HI;
    end else if (h < SAT_LO) begin
      h = SAT_LO;
    end
    return COORD_W'(h);
  endfunction

endpackage

`default_nettype wire

// ===== sv/catmull_rom_curve_tessellator.sv =====
// Uniform Catmull-Rom curve tessellator. Control points come in on the slave
// stream one word each (tlast marks the final point of a curve); curve samples
// leave on the master stream, with tlast on the last sample caused by each input
// word. From the third point on, each point yields one segment of n samples,
// n = samples_per_segment clamped to 2..32, and a final point also yields the
// closing segment, so a word causes 0, n or 2n samples. The sample sequencer
// issues one sample per cycle while the output is not stalled; a sample reaches
// the output via the three-multiply Horner pipeline and its output register.
// The front end computes segment coefficients and takes a new word each cycle
// while the two-entry segment queue has room; after a word that yields two
// segments it holds off until the closing segment goes into the queue.
// samples_per_segment sits at byte address 0 and resets to 16; write it only
// while the block is idle.
`default_nettype none

module catmull_rom_curve_tessellator
  import crt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Control point words.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // point_x [15:0], point_y [31:16]
  input  wire logic        s_axis_tlast,  // final_point
  // Curve sample words.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // sample_x [15:0], sample_y [31:16]
  output logic             m_axis_tlast,  // run_end
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [SPP_W-1:0] spp_q;
  logic [CNT_W-1:0] intervals;
  logic             room;
  logic             push;
  seg_t             push_seg;
  logic             pop;
  logic             head_vld;
  seg_t             head;
  logic signed [COORD_W-1:0] sample_x;
  logic signed [COORD_W-1:0] sample_y;

  // Register write; only word address 0 holds a register.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q <= SPP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      spp_q <= pwdata[SPP_W-1:0];
    end
  end
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - SPP_W){1'b0}}, spp_q} : '0;

  // Intervals per segment, from the clamped sample count.
  always_comb begin
    if (spp_q < MIN_SAMPLES) begin
      intervals = CNT_W'(MIN_SAMPLES - SPP_W'(1));
    end else if (spp_q > MAX_SAMPLES) begin
      intervals = CNT_W'(MAX_SAMPLES - SPP_W'(1));
    end else begin
      intervals = CNT_W'(spp_q - SPP_W'(1));
    end
  end

  crt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .point_x_i     (s_axis_tdata[15:0]),
    .point_y_i     (s_axis_tdata[31:16]),
    .final_point_i (s_axis_tlast),
    .room_i        (room),
    .push_o        (push),
    .push_seg_o    (push_seg)
  );

  crt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_seg_i (push_seg),
    .room_o     (room),
    .pop_i      (pop),
    .head_vld_o (head_vld),
    .head_o     (head)
  );

  crt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .intervals_i   (intervals),
    .head_vld_i    (head_vld),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sample_x_o    (sample_x),
    .sample_y_o    (sample_y),
    .run_end_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {sample_y, sample_x};

endmodule

`default_nettype wire

// ===== sv/crt_front.sv =====
`default_nettype none

module crt_front
  import crt_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic signed [COORD_W-1:0]  point_x_i,
  input  wire logic signed [COORD_W-1:0]  point_y_i,
  input  wire logic                       final_point_i,
  input  wire logic                       room_i,
  output logic                            push_o,
  output seg_t                            push_seg_o
);

  logic signed [COORD_W-1:0] hx_q [3];
  logic signed [COORD_W-1:0] hy_q [3];
  logic [1:0] seen_q;
  logic       pend_q;
  seg_t       pend_seg_q;

  logic take;
  logic has_mid;
  logic has_end;
  seg_t seg_mid;
  seg_t seg_end;

  // A word is taken only when the queue can hold its first segment.
  assign s_axis_tready = !pend_q && room_i;
  assign take = s_axis_tvalid && s_axis_tready;

  // Segment between the two previous points, and the closing segment.
  assign has_mid = seen_q[1];
  assign has_end = final_point_i && (seen_q != 2'd0);

  always_comb begin
    seg_mid.x = coef_f((seen_q == 2'd3) ? hx_q[0] : hx_q[1], hx_q[1], hx_q[2], point_x_i);
    seg_mid.y = coef_f((seen_q == 2'd3) ? hy_q[0] : hy_q[1], hy_q[1], hy_q[2], point_y_i);
    seg_mid.last = !has_end;
    seg_end.x = coef_f(seen_q[1] ? hx_q[1] : hx_q[2], hx_q[2], point_x_i, point_x_i);
    seg_end.y = coef_f(seen_q[1] ? hy_q[1] : hy_q[2], hy_q[2], point_y_i, point_y_i);
    seg_end.last = 1'b1;
  end

  // Push now, or hold the closing segment for the next free slot.
  assign push_o = (pend_q && room_i) || (take && (has_mid || has_end));
  assign push_seg_o = pend_q ? pend_seg_q : (has_mid ? seg_mid : seg_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (take && has_mid && has_end) begin
      pend_q <= 1'b1;
    end else if (pend_q && room_i) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && has_mid && has_end) begin
      pend_seg_q <= seg_end;
    end
  end

  // Point history; a final point clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        hx_q[i] <= '0;
        hy_q[i] <= '0;
      end
    end else if (take) begin
      if (final_point_i) begin
        seen_q <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          hx_q[i] <= '0;
          hy_q[i] <= '0;
        end
      end else begin
        if (seen_q != 2'd3) begin
          seen_q <= seen_q + 2'd1;
        end
        hx_q[0] <= hx_q[1];
        hy_q[0] <= hy_q[1];
        hx_q[1] <= hx_q[2];
        hy_q[1] <= hy_q[2];
        hx_q[2] <= point_x_i;
        hy_q[2] <= point_y_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/crt_fifo.sv =====
`default_nettype none

module crt_fifo
  import crt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire seg_t  push_seg_i,
  output logic       room_o,
  input  wire logic  pop_i,
  output logic       head_vld_o,
  output seg_t       head_o
);

  seg_t mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [PTR_W:0]   cnt_q;
  logic do_push;
  logic do_pop;

  assign room_o = cnt_q != (PTR_W + 1)'(FIFO_DEPTH);
  assign head_vld_o = cnt_q != '0;
  assign head_o = mem_q[rd_q];
  assign do_push = push_i && room_o;
  assign do_pop = pop_i && head_vld_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_seg_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/crt_back.sv =====
`default_nettype none

module crt_back
  import crt_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [CNT_W-1:0]           intervals_i,
  input  wire logic                       head_vld_i,
  input  wire seg_t                       head_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic signed [COORD_W-1:0]       sample_x_o,
  output logic signed [COORD_W-1:0]       sample_y_o,
  output logic                            run_end_o
);

  // Sample sequencer state.
  logic             active_q;
  coef_t            cf_q [2];
  logic             seg_last_q;
  logic [CNT_W-1:0] j_q;
  logic [T_W-1:0]   quot_q;
  logic [CNT_W-1:0] rem_q;

  // Pipeline stages.
  logic v1_q, v2_q, v3_q, ovld_q;
  logic l1_q, l2_q, l3_q, olast_q;
  logic [T_W-1:0] t1_q, t2_q;
  logic signed [PROD_W-1:0] p1_q [2];
  logic signed [PROD_W-1:0] p2_q [2];
  logic signed [PROD_W-1:0] p3_q [2];
  logic signed [COEF_W-1:0] c1_q [2];
  logic signed [COEF_W-1:0] b1_q [2];
  logic signed [COEF_W-1:0] b2_q [2];
  logic signed [COEF_W-1:0] a1_q [2];
  logic signed [COEF_W-1:0] a2_q [2];
  logic signed [COEF_W-1:0] a3_q [2];
  logic signed [COORD_W-1:0] ox_q, oy_q;

  logic en;
  logic issue;
  logic last_iss;
  tstep_t step;
  logic [CNT_W:0] rem_sum;
  logic carry;
  logic [CNT_W-1:0] rem_next;

  // The whole pipe moves unless a finished sample is held at the output.
  assign en = !ovld_q || m_axis_tready;
  assign issue = active_q && en;
  assign last_iss = j_q == intervals_i;
  assign pop_o = head_vld_i && (!active_q || (issue && last_iss));

  // Next t as quotient plus running remainder.
  assign step = tstep_f(intervals_i);
  assign rem_sum = {1'b0, rem_q} + {1'b0, step.r};
  assign carry = rem_sum >= {1'b0, intervals_i};
  assign rem_next = carry ? CNT_W'(rem_sum - {1'b0, intervals_i}) : CNT_W'(rem_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      j_q <= '0;
      quot_q <= '0;
      rem_q <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      j_q <= '0;
      quot_q <= '0;
      rem_q <= intervals_i >> 1;
    end else if (issue && last_iss) begin
      active_q <= 1'b0;
    end else if (issue) begin
      j_q <= j_q + CNT_W'(1);
      quot_q <= quot_q + step.q + T_W'(carry);
      rem_q <= rem_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cf_q[0] <= head_i.x;
      cf_q[1] <= head_i.y;
      seg_last_q <= head_i.last;
    end
  end

  // Stage valid bits and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ovld_q <= 1'b0;
    end else if (en) begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      ovld_q <= v3_q;
    end
  end

  // Horner's rule, one multiply per stage for each coordinate.
  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_q <= last_iss && seg_last_q;
      l2_q <= l1_q;
      l3_q <= l2_q;
      olast_q <= l3_q;
      t1_q <= quot_q;
      t2_q <= t1_q;
      for (int i = 0; i < 2; i++) begin
        p1_q[i] <= mul_f(ACC_W'(cf_q[i].d), quot_q);
        c1_q[i] <= cf_q[i].c;
        b1_q[i] <= cf_q[i].b;
        a1_q[i] <= cf_q[i].a;
        p2_q[i] <= mul_f(ACC_W'(c1_q[i]) + rnd_f(p1_q[i]), t1_q);
        b2_q[i] <= b1_q[i];
        a2_q[i] <= a1_q[i];
        p3_q[i] <= mul_f(ACC_W'(b2_q[i]) + rnd_f(p2_q[i]), t2_q);
        a3_q[i] <= a2_q[i];
      end
      ox_q <= fin_f(ACC_W'(a3_q[0]) + rnd_f(p3_q[0]));
      oy_q <= fin_f(ACC_W'(a3_q[1]) + rnd_f(p3_q[1]));
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign sample_x_o = ox_q;
  assign sample_y_o = oy_q;
  assign run_end_o = olast_q;

endmodule

`default_nettype wire
